// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/p2n_pkg.sv
// Package with the shared types and constants of the pitch-to-note run segmenter.
package p2n_pkg;

    // Width of a note index. Index NUM_BOUNDARIES - 1, the top one, means no note.
    localparam int unsigned NOTE_W = 6;

    // Width of a boundary in Q12.4 Hz, wide enough for up to 64 boundaries.
    localparam int unsigned BOUND_W = 17;

    // Tones of the lowest octave in Hz; boundary x is (tone - 10) << (x / 12 + 3).
    localparam int unsigned BASE_TONE [12] = '{
        261, 277, 293, 311, 329, 349, 370, 392, 415, 440, 466, 493
    };
    localparam int unsigned TONE_OFFSET = 10;
    localparam int unsigned TONES_PER_OCTAVE = 12;
    localparam int unsigned FRAC_SHIFT = 3;

    // Configuration register indexes.
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DURATION = 1'b0;
    localparam logic [7:0] MIN_DURATION_RESET = 8'd2;

    // Queue between the classifier and the run tracker.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              last;
    } queue_item_t;

endpackage

// File: design/p2n_front.sv
// Front end: accepts pitch requests and quantizes each one to a note index.
module p2n_front #(
    parameter int unsigned NUM_BOUNDARIES = 48
) (
    input  logic                 pitch_valid,
    output logic                 pitch_ready,
    input  logic [15:0]          freq,
    input  logic                 last,
    input  logic                 queue_full,
    output logic                 push,
    output p2n_pkg::queue_item_t push_item
);
    import p2n_pkg::*;

    localparam logic [NOTE_W-1:0] NO_NOTE = NOTE_W'(NUM_BOUNDARIES - 1);

    logic [NUM_BOUNDARIES-1:0] ge;
    logic [NUM_BOUNDARIES-2:0] hit;
    logic [BOUND_W-1:0]        freq_ext;
    logic [NOTE_W-1:0]         note_idx;

    assign freq_ext = BOUND_W'(freq);

    // Boundaries rise monotonically, so the compare bits form a thermometer code.
    for (genvar g = 0; g < NUM_BOUNDARIES; g++) begin : g_cmp
        localparam int unsigned OCT  = g / TONES_PER_OCTAVE;
        localparam int unsigned TONE = g % TONES_PER_OCTAVE;
        localparam logic [BOUND_W-1:0] BOUND =
            BOUND_W'((BASE_TONE[TONE] - TONE_OFFSET) << (OCT + FRAC_SHIFT));
        assign ge[g] = (freq_ext >= BOUND);
    end

    for (genvar h = 0; h < NUM_BOUNDARIES - 1; h++) begin : g_hit
        assign hit[h] = ge[h] & ~ge[h+1];
    end

    always_comb
    begin
        note_idx = '0;
        for (int i = 0; i < NUM_BOUNDARIES - 1; i++)
        begin
            if (hit[i])
            begin
                note_idx = note_idx | NOTE_W'(i);
            end
        end
        if (hit == '0)
        begin
            note_idx = NO_NOTE;
        end
    end

    assign pitch_ready    = ~queue_full;
    assign push           = pitch_valid & ~queue_full;
    assign push_item.note = note_idx;
    assign push_item.last = last;

endmodule

// File: design/p2n_queue.sv
// Short queue that decouples the classifier from the run tracker.
module p2n_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  p2n_pkg::queue_item_t push_item,
    input  logic                 pop,
    output p2n_pkg::queue_item_t pop_item,
    output logic                 full,
    output logic                 not_empty
);
    import p2n_pkg::*;

    queue_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/p2n_back.sv
// Back end: tracks the current run and registers each kept run, and each end of stream, as a result.
module p2n_back #(
    parameter int unsigned DURATION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  p2n_pkg::queue_item_t       item,
    output logic                       pop,
    input  logic [7:0]                 min_duration,
    output logic                       note_valid,
    input  logic                       note_ready,
    output logic [p2n_pkg::NOTE_W-1:0] note,
    output logic [DURATION_BITS-1:0]   duration,
    output logic                       stream_end,
    output logic                       empty_res
);
    import p2n_pkg::*;

    localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;
    localparam logic [DURATION_BITS-1:0] DUR_ONE = DURATION_BITS'(1);

    logic [NOTE_W-1:0]        run_note_reg, run_note_next;
    logic [DURATION_BITS-1:0] run_length_reg, run_length_next;
    logic                     run_active_reg, run_active_next;
    logic                     any_emitted_reg, any_emitted_next;

    logic                     res_valid_reg, res_valid_next;
    logic [NOTE_W-1:0]        res_note_reg, res_note_next;
    logic [DURATION_BITS-1:0] res_dur_reg, res_dur_next;
    logic                     res_end_reg, res_end_next;
    logic                     res_empty_reg, res_empty_next;

    logic [DURATION_BITS-1:0] min_ext;
    logic                     change;
    logic                     keep_prev;
    logic                     have;

    assign min_ext = DURATION_BITS'(min_duration);
    assign pop     = item_valid & (~res_valid_reg | note_ready);

    always_comb
    begin
        run_note_next    = run_note_reg;
        run_length_next  = run_length_reg;
        run_active_next  = run_active_reg;
        any_emitted_next = any_emitted_reg;
        res_valid_next   = res_valid_reg & ~note_ready;
        res_note_next    = res_note_reg;
        res_dur_next     = res_dur_reg;
        res_end_next     = res_end_reg;
        res_empty_next   = res_empty_reg;

        change    = run_active_reg & (item.note != run_note_reg);
        keep_prev = ~any_emitted_reg | (run_length_reg >= min_ext);
        have      = change & keep_prev;

        if (pop)
        begin
            if (change)
            begin
                run_note_next    = item.note;
                run_length_next  = DUR_ONE;
                any_emitted_next = any_emitted_reg | keep_prev;
            end
            else if (run_active_reg)
            begin
                if (run_length_reg != DUR_MAX)
                begin
                    run_length_next = run_length_reg + DUR_ONE;
                end
            end
            else
            begin
                run_note_next   = item.note;
                run_length_next = DUR_ONE;
                run_active_next = 1'b1;
            end

            res_valid_next = have | item.last;
            res_end_next   = item.last;
            res_empty_next = 1'b0;
            res_note_next  = run_note_reg;
            res_dur_next   = run_length_reg;

            if (item.last)
            begin
                // Without a closed previous run, the final run goes out if it is kept, else an empty result.
                if (!have)
                begin
                    if (!any_emitted_reg || (run_length_next >= min_ext))
                    begin
                        res_note_next = run_note_next;
                        res_dur_next  = run_length_next;
                    end
                    else
                    begin
                        res_note_next  = '0;
                        res_dur_next   = '0;
                        res_empty_next = 1'b1;
                    end
                end
                run_note_next    = '0;
                run_length_next  = '0;
                run_active_next  = 1'b0;
                any_emitted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_note_reg    <= '0;
            run_length_reg  <= '0;
            run_active_reg  <= 1'b0;
            any_emitted_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            run_note_reg    <= run_note_next;
            run_length_reg  <= run_length_next;
            run_active_reg  <= run_active_next;
            any_emitted_reg <= any_emitted_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_note_reg  <= res_note_next;
        res_dur_reg   <= res_dur_next;
        res_end_reg   <= res_end_next;
        res_empty_reg <= res_empty_next;
    end

    assign note_valid = res_valid_reg;
    assign note       = res_note_reg;
    assign duration   = res_dur_reg;
    assign stream_end = res_end_reg;
    assign empty_res  = res_empty_reg;

endmodule

// File: design/pitch_to_note_run_segmenter.sv
// Top level of the pitch-to-note run segmenter: register port, front end, queue, back end.
//
//   Channel   Handshake                 Payload
//   pitch     pitch_valid/pitch_ready   freq[15:0], last
//   note      note_valid/note_ready     note[5:0], duration, stream_end, empty_res
//   config    APB psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
// One request is taken every cycle as long as the two-entry queue has room.
// A taken request is first written into the queue; the run tracker then pops it and
// registers any result that it produces, so no request turns into a result at the
// edge where it is taken.
// The run tracker advances one queued request per cycle while the result register is
// empty or its result is being taken, so a stalled note channel backs up the queue
// first and only then drops pitch_ready. Reset clears the run state, the queue and the
// result valid flag at once and sets min_duration to 2; no clearing pass is needed.
module pitch_to_note_run_segmenter #(
    parameter int unsigned NUM_BOUNDARIES = 48,
    parameter int unsigned DURATION_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,

    input  logic                       pitch_valid,
    output logic                       pitch_ready,
    input  logic [15:0]                freq,
    input  logic                       last,

    output logic                       note_valid,
    input  logic                       note_ready,
    output logic [p2n_pkg::NOTE_W-1:0] note,
    output logic [DURATION_BITS-1:0]   duration,
    output logic                       stream_end,
    output logic                       empty_res
);
    import p2n_pkg::*;

    logic [7:0]           min_duration_reg, min_duration_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_not_empty;
    queue_item_t          push_item;
    queue_item_t          pop_item;

    // Registers sit on 32-bit words; the byte offset bits are ignored.
    assign reg_idx   = paddr[2 +: REG_IDX_W];
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_comb
    begin
        min_duration_next = min_duration_reg;
        if (cfg_write && (reg_idx == REG_MIN_DURATION))
        begin
            min_duration_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_DURATION: prdata = {24'd0, min_duration_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duration_reg <= MIN_DURATION_RESET;
        end
        else
        begin
            min_duration_reg <= min_duration_next;
        end
    end

    // The front end quantizes each request against the boundary table combinationally.
    p2n_front #(
        .NUM_BOUNDARIES (NUM_BOUNDARIES)
    ) u_front (
        .pitch_valid (pitch_valid),
        .pitch_ready (pitch_ready),
        .freq        (freq),
        .last        (last),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    // The queue lets the pitch side keep moving while a result waits to be taken.
    p2n_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    // The back end extends or closes the current run and registers any result.
    p2n_back #(
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_not_empty),
        .item         (pop_item),
        .pop          (pop),
        .min_duration (min_duration_reg),
        .note_valid   (note_valid),
        .note_ready   (note_ready),
        .note         (note),
        .duration     (duration),
        .stream_end   (stream_end),
        .empty_res    (empty_res)
    );

endmodule

// File: design/p2n_checker.sv
// Port-level checker for the pitch-to-note run segmenter, with its bind.
`include "assert_macros.svh"

module p2n_checker #(
    parameter int unsigned DURATION_BITS = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pready,
    input logic                       note_valid,
    input logic                       note_ready,
    input logic [p2n_pkg::NOTE_W-1:0] note,
    input logic [DURATION_BITS-1:0]   duration,
    input logic                       stream_end,
    input logic                       empty_res
);
    import p2n_pkg::*;

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_res_hold, note_valid && !note_ready, note_valid && $stable(note) && $stable(duration) && $stable(stream_end) && $stable(empty_res), "result changed while stalled")

    // Only the end-of-stream result may come without a run.
    `ASSERT_SAME(a_empty_end, note_valid && empty_res, stream_end, "empty result without stream end")

    // An empty result carries zero note and duration.
    `ASSERT_SAME(a_empty_zero, note_valid && empty_res, note == '0 && duration == '0, "empty result has nonzero fields")

    // Every run that is reported covers at least one sample.
    `ASSERT_SAME(a_run_len, note_valid && !empty_res, duration != '0, "run with zero duration")

    // The register port never waits.
    `ASSERT_SAME(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind pitch_to_note_run_segmenter p2n_checker #(
    .DURATION_BITS (DURATION_BITS)
) u_p2n_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .note_valid (note_valid),
    .note_ready (note_ready),
    .note       (note),
    .duration   (duration),
    .stream_end (stream_end),
    .empty_res  (empty_res)
);

// File: verif/tb_top.sv
// Self-checking testbench for the pitch-to-note run segmenter.
`timescale 1ns / 100ps

module tb_top;

    import p2n_pkg::NOTE_W;
    import p2n_pkg::REG_MIN_DURATION;

    // Geometry of the block as built by default.
    localparam int unsigned NUM_NOTES = 48;
    localparam int unsigned DUR_W = 16;
    localparam logic [NOTE_W-1:0] NO_NOTE = NOTE_W'(NUM_NOTES - 1);
    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    // Register map: min_duration is register 0, one 32-bit word per register.
    localparam logic [2:0] MIN_DUR_ADDR = {REG_MIN_DURATION, 2'b00};
    localparam logic [7:0] MIN_DUR_AT_RESET = 8'd2;

    // A few pitches in the middle of well separated note bands.
    localparam logic [15:0] FREQ_A = 16'd3500;
    localparam logic [15:0] FREQ_B = 16'd5000;
    localparam logic [15:0] FREQ_C = 16'd8000;

    // No request is answered at the edge where it is taken, and at most a queue of two
    // plus the result register can be in flight, so a handful of cycles settles it.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned END_WAIT_CYCLES = 5000;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 150;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [DUR_W-1:0]  duration;
        logic              stream_end;
        logic              empty_res;
    } note_run_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              pitch_valid;
    logic              pitch_ready;
    logic [15:0]       freq;
    logic              last;
    logic              note_valid;
    logic              note_ready;
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  duration;
    logic              stream_end;
    logic              empty_res;

    // Mirror of the run tracker and of the configuration register.
    logic [7:0]        min_dur = MIN_DUR_AT_RESET;
    logic [NOTE_W-1:0] trk_note = '0;
    logic [DUR_W-1:0]  trk_len = '0;
    bit                trk_active = 1'b0;
    bit                trk_emitted = 1'b0;

    // Runs predicted but not yet seen on the note channel, oldest first.
    note_run_t runs_due[$];
    note_run_t got_run;

    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    // When set, the sender or the receiver runs without gaps.
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;

    pitch_to_note_run_segmenter dut (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ---------------------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------------------

    function automatic int unsigned tone_hz(input int unsigned k);
        case (k)
            0:       return 261;
            1:       return 277;
            2:       return 293;
            3:       return 311;
            4:       return 329;
            5:       return 349;
            6:       return 370;
            7:       return 392;
            8:       return 415;
            9:       return 440;
            10:      return 466;
            default: return 493;
        endcase
    endfunction

    // Lower boundary of note x in Q12.4 Hz: half of (tone - 10 Hz) scaled by the octave.
    // In Q12.4 that is an exact left shift, so no rounding enters anywhere.
    function automatic int unsigned bound_q4(input int unsigned x);
        return (tone_hz(x % 12) - 10) << (x / 12 + 3);
    endfunction

    // Note index of a pitch; anything below the lowest or at or above the highest
    // boundary lands on the no-note index.
    function automatic logic [NOTE_W-1:0] note_of(input logic [15:0] f);
        logic [NOTE_W-1:0] idx;
        bit                found;
        idx = NO_NOTE;
        found = 1'b0;
        if (f >= bound_q4(0)) begin
            for (int unsigned i = 1; i < NUM_NOTES; i++) begin
                if (!found && f < bound_q4(i)) begin
                    idx = NOTE_W'(i - 1);
                    found = 1'b1;
                end
            end
        end
        return idx;
    endfunction

    // The first run of a stream always survives; later ones need min_duration samples.
    function automatic bit run_is_kept(input logic [DUR_W-1:0] len);
        return !trk_emitted || (len >= DUR_W'(min_dur));
    endfunction

    // Advance the mirrored tracker by one accepted request and queue whatever run it closes.
    task automatic predict_note_runs(input logic [15:0] f, input logic is_last);
        logic [NOTE_W-1:0] q;
        bit                have;
        note_run_t         closed;
        q = note_of(f);
        have = 1'b0;
        closed = '0;
        if (trk_active && q != trk_note) begin
            // A note change closes the run in progress; short runs vanish silently.
            if (run_is_kept(trk_len)) begin
                have = 1'b1;
                closed.note = trk_note;
                closed.duration = trk_len;
                trk_emitted = 1'b1;
            end
            trk_note = q;
            trk_len = 1;
        end else if (trk_active) begin
            if (trk_len != DUR_MAX)
                trk_len++;
        end else begin
            trk_note = q;
            trk_len = 1;
            trk_active = 1'b1;
        end
        if (is_last) begin
            // The end of a stream always yields one result. A run closed by this very
            // sample wins over the one-sample final run, which is then discarded.
            closed.stream_end = 1'b1;
            if (!have) begin
                if (run_is_kept(trk_len)) begin
                    closed.note = trk_note;
                    closed.duration = trk_len;
                end else begin
                    closed.empty_res = 1'b1;
                end
            end
            runs_due.push_back(closed);
            trk_note = '0;
            trk_len = '0;
            trk_active = 1'b0;
            trk_emitted = 1'b0;
        end else if (have) begin
            runs_due.push_back(closed);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------------------

    task automatic check_field(input string fname, input logic [31:0] want_v, got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want_v, got_v);
        end
    endtask

    // Results are checked before requests are predicted, since no request can turn into
    // a result at the edge where it is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (note_valid && note_ready) begin
                if (runs_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got note %0d duration %0d",
                             $time, note, duration);
                end else begin
                    got_run = runs_due.pop_front();
                    check_field("note", got_run.note, note);
                    check_field("duration", got_run.duration, duration);
                    check_field("stream_end", got_run.stream_end, stream_end);
                    check_field("empty_res", got_run.empty_res, empty_res);
                end
            end
            if (pitch_valid && pitch_ready)
                predict_note_runs(freq, last);
        end
    end

    // A hung handshake must not hang the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Note channel receiver: a random stall before each result, none while sink_calm is set.
    // ---------------------------------------------------------------------------------

    initial begin
        int unsigned hold;
        note_ready = 1'b0;
        @(negedge clk);
        forever begin
            hold = sink_calm ? 0 : $urandom_range(13, 0);
            if (hold != 0) begin
                note_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            note_ready <= 1'b1;
            @(posedge clk);
            while (!note_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------------------------
    // Shared drivers. All of them start and end on a falling edge.
    // ---------------------------------------------------------------------------------

    // Send one pitch request after a random gap. With no gap, valid simply stays high
    // and the next payload follows right behind the previous one.
    task automatic send_pitch(input logic [15:0] f, input logic is_last);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(13, 0);
        if (gap != 0) begin
            pitch_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pitch_valid <= 1'b1;
        freq <= f;
        last <= is_last;
        @(posedge clk);
        while (!pitch_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender off until every predicted result has been taken, then let the
    // block finish any request that closes nothing.
    task automatic wait_results_idle();
        pitch_valid <= 1'b0;
        @(negedge clk);
        while (runs_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write min_duration, then read it straight back in a second transfer.
    task automatic set_min_duration(input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MIN_DUR_ADDR;
        pwdata <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        min_dur = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        check_field("min_duration readback", min_dur, prdata[7:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random pitch inside the band of note n; the no-note band lies on both sides.
    function automatic logic [15:0] band_freq(input logic [NOTE_W-1:0] n);
        int unsigned lo;
        int unsigned hi;
        if (n == NO_NOTE) begin
            if ($urandom_range(1, 0) == 0) begin
                lo = 0;
                hi = bound_q4(0) - 1;
            end else begin
                lo = bound_q4(NUM_NOTES - 1);
                hi = 32'hFFFF;
            end
        end else begin
            lo = bound_q4(n);
            hi = bound_q4(n + 1) - 1;
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // A stream of one sample is its own first run, so it is always reported.
    task automatic test_single_sample_stream();
        send_pitch(FREQ_B, 1'b1);
    endtask

    // With the reset minimum of two, the lone B and lone C samples are both too short,
    // so the end of the stream carries no run.
    task automatic test_nothing_to_emit();
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_B, 1'b0);
        send_pitch(FREQ_C, 1'b1);
    endtask

    // One-sample runs straddling the lowest and highest boundaries, plus both ends of
    // the pitch range. With a minimum of one every run but the final one is reported.
    task automatic test_note_boundaries();
        wait_results_idle();
        set_min_duration(8'd1);
        send_pitch(16'd0, 1'b0);
        send_pitch(16'(bound_q4(0)), 1'b0);
        send_pitch(16'(bound_q4(0) - 1), 1'b0);
        send_pitch(16'(bound_q4(NUM_NOTES - 1) - 1), 1'b0);
        send_pitch(16'hFFFF, 1'b0);
        send_pitch(16'(bound_q4(NUM_NOTES - 2)), 1'b0);
        send_pitch(16'(bound_q4(NUM_NOTES - 1)), 1'b0);
        send_pitch(16'(bound_q4(NUM_NOTES - 2) - 1), 1'b0);
        send_pitch(16'h8000, 1'b1);
    endtask

    // The last sample closes a kept run and would be kept itself: only the older
    // run comes out, marked as the end of the stream.
    task automatic test_two_runs_at_end();
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_B, 1'b1);
    endtask

    // Largest minimum: a run one short of it is dropped, a run of exactly it is kept.
    task automatic test_min_duration_max();
        wait_results_idle();
        set_min_duration(8'd255);
        repeat (3) send_pitch(FREQ_A, 1'b0);
        repeat (254) send_pitch(FREQ_B, 1'b0);
        repeat (255) send_pitch(FREQ_C, 1'b0);
        send_pitch(FREQ_A, 1'b0);
        send_pitch(FREQ_B, 1'b1);
    endtask

    // Random streams of runs whose lengths sit around the current minimum, with some
    // noise samples mixed in. Several minimum settings are visited, and now and then
    // the sender waits for the receiver to catch up completely.
    task automatic test_random_streams(input int unsigned goal);
        int unsigned       sent;
        int unsigned       streams;
        int unsigned       n_runs;
        int unsigned       run_len;
        logic [NOTE_W-1:0] pick;
        logic [15:0]       f;
        sent = 0;
        streams = 0;
        for (int unsigned phase = 0; phase < 4; phase++) begin
            wait_results_idle();
            case (phase)
                0:       set_min_duration(8'd1);
                1:       set_min_duration(8'd2);
                default: set_min_duration(8'($urandom_range(12, 3)));
            endcase
            while (sent < goal * (phase + 1) / 4) begin
                src_calm = ($urandom_range(3, 0) == 0);
                sink_calm = ($urandom_range(3, 0) == 0);
                n_runs = $urandom_range(6, 1);
                for (int unsigned r = 0; r < n_runs; r++) begin
                    pick = NOTE_W'($urandom_range(NUM_NOTES - 1, 0));
                    case ($urandom_range(3, 0))
                        0:       run_len = (min_dur > 1) ? min_dur - 1 : 1;
                        1:       run_len = min_dur;
                        default: run_len = $urandom_range(min_dur + 3, 1);
                    endcase
                    if ($urandom_range(9, 0) == 0)
                        run_len = 1;
                    for (int unsigned k = 0; k < run_len; k++) begin
                        if ($urandom_range(11, 0) == 0)
                            f = 16'($urandom_range(32'hFFFF, 0));
                        else
                            f = band_freq(pick);
                        send_pitch(f, (r == n_runs - 1) && (k == run_len - 1));
                        sent++;
                    end
                end
                streams++;
                if (streams % 7 == 0)
                    wait_results_idle();
            end
        end
        src_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------

    initial begin
        int unsigned spin;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pitch_valid = 1'b0;
        freq = '0;
        last = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_sample_stream();
        test_nothing_to_emit();
        test_note_boundaries();
        test_two_runs_at_end();
        test_min_duration_max();
        test_random_streams(RANDOM_ITEMS);

        // Let the last results drain; anything still predicted afterwards is missing.
        pitch_valid <= 1'b0;
        spin = 0;
        while (runs_due.size() != 0 && spin < END_WAIT_CYCLES) begin
            @(negedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (runs_due.size() != 0) begin
            errors += runs_due.size();
            $display("%0t: %0d expected results never arrived", $time, runs_due.size());
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/p2n_pkg.sv
design/p2n_front.sv
design/p2n_queue.sv
design/p2n_back.sv
design/pitch_to_note_run_segmenter.sv
design/p2n_checker.sv
verif/tb_top.sv
